// File: design/mvae_pkg.sv
package mvae_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_KEYON  = 3'd1;
    localparam logic [2:0] KIND_KEYOFF = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_SET    = 3'd4;

    // envelope phases
    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_STOPPED = 3'd4;

    localparam logic [14:0] LEVEL_MAX  = 15'h7fff;
    localparam logic [14:0] EXP_KNEE   = 15'h6000;
    localparam logic [15:0] CNT_START  = 16'h8000;
    localparam logic [3:0]  STEP_DOWN  = 4'b1000;   // -8

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  voice;
        logic [15:0] adsr_first_word;
        logic [15:0] adsr_second_word;
    } t_item;

    typedef struct packed {
        logic [14:0] env_level_out;
        logic [2:0]  phase_out;
        logic        running_out;
    } t_result;

    // rate parameters of the current phase
    typedef struct packed {
        logic        decreasing;
        logic        exponential;
        logic [4:0]  shift;
        logic [3:0]  step;      // two's complement
        logic [15:0] target;
        logic        endless;
    } t_cache;

    // one voice table entry
    typedef struct packed {
        logic [15:0] adsr_first;
        logic [15:0] adsr_second;
        logic [14:0] level;
        logic [15:0] counter;
        logic [2:0]  phase;
        logic        active;
        t_cache      cache;
    } t_entry;

    function automatic t_cache decode_phase(
        input logic [2:0]  ph,
        input logic [15:0] a,
        input logic [15:0] b,
        input t_cache      old
    );
        t_cache c;
        c = old;
        case (ph)
            PH_ATTACK: begin
                c.decreasing  = 1'b0;
                c.exponential = a[15];
                c.shift       = a[14:10];
                c.step        = 4'd7 - {2'b00, a[9:8]};
                c.target      = {1'b0, LEVEL_MAX};
                c.endless     = (a[14:8] == 7'h7f);
            end
            PH_DECAY: begin
                c.decreasing  = 1'b1;
                c.exponential = 1'b1;
                c.shift       = {1'b0, a[7:4]};
                c.step        = STEP_DOWN;
                c.target      = {({1'b0, a[3:0]} + 5'd1), 11'd0};
                c.endless     = (a[7:4] == 4'hf);
            end
            PH_SUSTAIN: begin
                c.decreasing  = b[14];
                c.exponential = b[15];
                c.shift       = b[12:8];
                c.step        = b[14] ? ({2'b00, b[7:6]} + STEP_DOWN)
                                      : (4'd7 - {2'b00, b[7:6]});
                c.target      = 16'd0;
                c.endless     = (b[12:6] == 7'h7f);
            end
            PH_RELEASE: begin
                c.decreasing  = 1'b1;
                c.exponential = b[5];
                c.shift       = b[4:0];
                c.step        = STEP_DOWN;
                c.target      = 16'd0;
                c.endless     = (b[4:0] == 5'h1f);
            end
            default: begin
                c = old;
            end
        endcase
        return c;
    endfunction

endpackage

// File: design/mvae_ram.sv
module mvae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: design/multi_voice_adsr_envelope.sv
// A taken beat passes the table read, the rate math with the level multiply (state
// CALC) and the write-back (state WB), then is registered and shown with o_strobe.
// busy is high in CALC and WB, so a new beat is taken only once the last is through.
// Reset (i_rst_n low, synchronous) clears the control state and the per-voice valid
// bits, so every voice reads as all-zero until first written. No clearing pass needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multi_voice_adsr_envelope #(
    parameter int VOICES = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mvae_pkg::t_item   i_item,
    output logic              o_strobe,
    output mvae_pkg::t_result o_result
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int EW = $bits(mvae_pkg::t_entry);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]        r_state, n_state;
    mvae_pkg::t_item   r_item;
    logic              r_inrange;
    logic              r_vld;
    logic [VOICES-1:0] r_valid;

    // stage registers between rate math and write-back
    mvae_pkg::t_entry  r_ent;
    logic signed [15:0] r_linc;
    logic [15:0]       r_cinc;

    logic              r_strobe;
    mvae_pkg::t_result r_result;

    logic              accept;
    logic [AW-1:0]     rd_idx;
    logic [AW-1:0]     wr_idx;
    logic [EW-1:0]     ram_rdata;
    logic              ram_we;
    mvae_pkg::t_entry  ent_rd;
    mvae_pkg::t_entry  ent_wb;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign rd_idx = i_item.voice[AW-1:0];
    assign wr_idx = r_item.voice[AW-1:0];

    // ---------------------------------------------------------------
    // voice table: one entry per voice, registered read
    // ---------------------------------------------------------------
    mvae_ram #(
        .WIDTH (EW),
        .DEPTH (VOICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (ent_wb),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // never-written voices read as the reset entry (all zero, phase attack)
    assign ent_rd = r_vld ? mvae_pkg::t_entry'(ram_rdata) : '0;

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_CALC;
            end
            ST_CALC: n_state = ST_WB;
            ST_WB:   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_WB);
            if (ram_we) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_item;
            r_inrange <= ({1'b0, i_item.voice} < 7'(VOICES));
            r_vld     <= r_valid[rd_idx];
        end
    end

    // ---------------------------------------------------------------
    // rate math: counter increment and level step for a tick
    // ---------------------------------------------------------------
    logic [4:0]         sh;
    logic [4:0]         csh;
    logic [3:0]         lsh;
    logic [15:0]        cinc;
    logic signed [15:0] lbase;
    logic signed [15:0] linc;
    logic signed [31:0] prod;

    always_comb begin
        sh    = ent_rd.cache.shift;
        csh   = (sh > 5'd11) ? (sh - 5'd11) : 5'd0;
        lsh   = (sh < 5'd11) ? 4'(5'd11 - sh) : 4'd0;
        cinc  = mvae_pkg::CNT_START >> csh;
        lbase = $signed({{12{ent_rd.cache.step[3]}}, ent_rd.cache.step}) <<< lsh;
        prod  = lbase * $signed({17'd0, ent_rd.level});
        linc  = lbase;
        if (ent_rd.cache.exponential && !ent_rd.cache.decreasing
                && (ent_rd.level >= mvae_pkg::EXP_KNEE)) begin
            // slow the rise near full scale
            if (sh < 5'd10) begin
                linc = lbase >>> 2;
            end else if (sh >= 5'd11) begin
                cinc = cinc >> 2;
            end else begin
                cinc = cinc >> 1;
                linc = lbase >>> 1;
            end
        end else if (ent_rd.cache.exponential && ent_rd.cache.decreasing) begin
            // step scaled by level, floor of the /32768
            linc = prod[30:15];
        end
        if (!ent_rd.cache.endless && (cinc == 16'd0)) begin
            cinc = 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_ent  <= ent_rd;
            r_linc <= linc;
            r_cinc <= cinc;
        end
    end

    // ---------------------------------------------------------------
    // write-back: apply the item to the entry
    // ---------------------------------------------------------------
    logic [16:0]        csum;
    logic signed [16:0] lsum;
    logic [14:0]        lvl_new;
    logic               hit;

    always_comb begin
        ent_wb  = r_ent;
        csum    = {1'b0, r_ent.counter} + {1'b0, r_cinc};
        lsum    = $signed({2'b00, r_ent.level}) + $signed({r_linc[15], r_linc});
        if (lsum < 0) begin
            lvl_new = 15'd0;
        end else if (lsum > $signed({2'b00, mvae_pkg::LEVEL_MAX})) begin
            lvl_new = mvae_pkg::LEVEL_MAX;
        end else begin
            lvl_new = lsum[14:0];
        end
        hit = 1'b0;

        case (r_item.kind)
            mvae_pkg::KIND_TICK: begin
                if (r_ent.active) begin
                    if (csum[15]) begin
                        ent_wb.counter = 16'd0;
                        ent_wb.level   = lvl_new;
                    end else begin
                        ent_wb.counter = csum[15:0];
                    end
                    if (r_ent.phase != mvae_pkg::PH_SUSTAIN) begin
                        hit = (!r_ent.cache.decreasing
                                  && ({1'b0, ent_wb.level} >= r_ent.cache.target))
                           || (r_ent.cache.decreasing
                                  && ({1'b0, ent_wb.level} <= r_ent.cache.target));
                        if (hit) begin
                            if (r_ent.phase < mvae_pkg::PH_STOPPED) begin
                                ent_wb.phase = r_ent.phase + 3'd1;
                            end
                            ent_wb.cache = mvae_pkg::decode_phase(ent_wb.phase,
                                r_ent.adsr_first, r_ent.adsr_second, r_ent.cache);
                        end
                        if (ent_wb.phase > mvae_pkg::PH_RELEASE) begin
                            ent_wb.active = 1'b0;
                        end
                    end
                end
            end
            mvae_pkg::KIND_KEYON: begin
                ent_wb.active  = 1'b1;
                ent_wb.level   = 15'd0;
                ent_wb.counter = 16'd0;
                ent_wb.phase   = mvae_pkg::PH_ATTACK;
                ent_wb.cache   = mvae_pkg::decode_phase(mvae_pkg::PH_ATTACK,
                    r_ent.adsr_first, r_ent.adsr_second, r_ent.cache);
            end
            mvae_pkg::KIND_KEYOFF: begin
                // inactive voices still move to release, as long as not already in release or stopped
                if (r_ent.phase < mvae_pkg::PH_RELEASE) begin
                    ent_wb.phase = mvae_pkg::PH_RELEASE;
                    ent_wb.cache = mvae_pkg::decode_phase(mvae_pkg::PH_RELEASE,
                        r_ent.adsr_first, r_ent.adsr_second, r_ent.cache);
                end
            end
            mvae_pkg::KIND_STOP: begin
                ent_wb.level  = 15'd0;
                ent_wb.phase  = mvae_pkg::PH_STOPPED;
                ent_wb.active = 1'b0;
            end
            mvae_pkg::KIND_SET: begin
                // cached rates stay until the next phase change or key on
                ent_wb.adsr_first  = r_item.adsr_first_word;
                ent_wb.adsr_second = r_item.adsr_second_word;
            end
            default: begin
                ent_wb = r_ent;
            end
        endcase
    end

    assign ram_we = (r_state == ST_WB) && r_inrange;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB) begin
            if (r_inrange) begin
                r_result.env_level_out <= ent_wb.level;
                r_result.phase_out     <= ent_wb.phase;
                r_result.running_out   <= ent_wb.active;
            end else begin
                // voice beyond the table: report a silent stopped voice
                r_result.env_level_out <= 15'd0;
                r_result.phase_out     <= mvae_pkg::PH_STOPPED;
                r_result.running_out   <= 1'b0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: design/mvae_checker.sv
module mvae_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input mvae_pkg::t_result o_result
);

    // an accepted beat blocks further beats
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // fixed latency from accept to result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("result missing three cycles after accept");

    // a result is shown only once the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a stopped voice never reports running
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.phase_out == mvae_pkg::PH_STOPPED))
            |-> !o_result.running_out)
        else $error("stopped voice reported running");

endmodule

bind multi_voice_adsr_envelope mvae_checker u_mvae_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: test/multi_voice_adsr_envelope_tb.sv
module multi_voice_adsr_envelope_tb;

    localparam int NUM_VOICES   = 48;
    localparam int TARGET_BEATS = 1350;   // beats sent over the whole run
    localparam int DRAIN_EVERY  = 400;    // sender holds off until the pipe is empty
    localparam int TAIL_CYCLES  = 8;      // pipe is 3 deep, give it a little extra
    localparam int TIME_LIMIT   = 5_000_000;

    // kinds 5..7 are not decoded by the block; one stands for all of them here
    localparam logic [2:0] KIND_RSVD = 3'd7;

    // one line of the directed table: the beat, and a typed-in result where the
    // answer is obvious; otherwise the envelope predictor supplies it
    typedef struct packed {
        mvae_pkg::t_item   beat;
        logic              typed;
        mvae_pkg::t_result want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    mvae_pkg::t_item   i_item  = '0;
    logic              o_strobe;
    mvae_pkg::t_result o_result;

    multi_voice_adsr_envelope #(
        .VOICES(NUM_VOICES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Envelope predictor: our own copy of the voice table
    // ------------------------------------------------------------------
    logic [15:0] vc_first   [NUM_VOICES];
    logic [15:0] vc_second  [NUM_VOICES];
    logic [14:0] vc_level   [NUM_VOICES];
    logic [15:0] vc_count   [NUM_VOICES];
    logic [2:0]  vc_phase   [NUM_VOICES];
    logic        vc_on      [NUM_VOICES];
    // rate parameters of the phase the voice is in
    logic        vc_dec     [NUM_VOICES];
    logic        vc_exp     [NUM_VOICES];
    int          vc_shift   [NUM_VOICES];
    int          vc_step    [NUM_VOICES];
    int          vc_target  [NUM_VOICES];
    logic        vc_endless [NUM_VOICES];

    mvae_pkg::t_result expected_env [$];   // results still owed by the block, oldest first
    bit                beat_live;          // last beat changed some state

    int errors          = 0;
    int beats_sent      = 0;
    int live_beats      = 0;
    int results_checked = 0;
    int keyons          = 0;
    int releases_done   = 0;
    int calm_left       = 0;

    // Latch the rate fields of the voice's current phase from its ADSR words.
    // Stopped keeps whatever was there (release values at the end of a note).
    function automatic void load_rates(input int n);
        logic [15:0] a;
        logic [15:0] b;
        a = vc_first[n];
        b = vc_second[n];
        case (vc_phase[n])
            mvae_pkg::PH_ATTACK: begin
                vc_dec[n]     = 1'b0;
                vc_exp[n]     = a[15];
                vc_shift[n]   = int'(a[14:10]);
                vc_step[n]    = 7 - int'(a[9:8]);
                vc_target[n]  = int'(mvae_pkg::LEVEL_MAX);
                vc_endless[n] = (a[14:8] == 7'h7f);
            end
            mvae_pkg::PH_DECAY: begin
                vc_dec[n]     = 1'b1;
                vc_exp[n]     = 1'b1;
                vc_shift[n]   = int'(a[7:4]);
                vc_step[n]    = -8;
                vc_target[n]  = (int'(a[3:0]) + 1) << 11;
                vc_endless[n] = (a[7:4] == 4'hf);
            end
            mvae_pkg::PH_SUSTAIN: begin
                vc_dec[n]     = b[14];
                vc_exp[n]     = b[15];
                vc_shift[n]   = int'(b[12:8]);
                vc_step[n]    = b[14] ? int'(b[7:6]) - 8 : 7 - int'(b[7:6]);
                vc_target[n]  = 0;
                vc_endless[n] = (b[12:6] == 7'h7f);
            end
            mvae_pkg::PH_RELEASE: begin
                vc_dec[n]     = 1'b1;
                vc_exp[n]     = b[5];
                vc_shift[n]   = int'(b[4:0]);
                vc_step[n]    = -8;
                vc_target[n]  = 0;
                vc_endless[n] = (b[4:0] == 5'h1f);
            end
            default: begin
            end
        endcase
    endfunction

    // One tick of a running voice: bump the rate counter, step the level when
    // bit 15 is reached, then check the phase target.
    function automatic void step_envelope(input int n);
        int          sh;
        int          linc;
        int          lvl;
        int unsigned cinc;
        int unsigned cnt;
        sh   = vc_shift[n];
        cinc = 32'(mvae_pkg::CNT_START) >> (sh > 11 ? sh - 11 : 0);
        linc = vc_step[n] * (1 << (sh < 11 ? 11 - sh : 0));
        lvl  = int'(vc_level[n]);

        // exponential rise slows above the knee; exponential fall scales with level
        // (>>> on a signed int floors toward minus infinity)
        if (vc_exp[n] && !vc_dec[n] && lvl >= int'(mvae_pkg::EXP_KNEE)) begin
            if (sh < 10) begin
                linc = (linc * 8192) >>> 15;
            end else if (sh >= 11) begin
                cinc = cinc >> 2;
            end else begin
                cinc = cinc >> 1;
                linc = (linc * 16384) >>> 15;
            end
        end else if (vc_exp[n] && vc_dec[n]) begin
            linc = (linc * lvl) >>> 15;
        end

        // only an endless rate may sit with a zero increment
        if (!vc_endless[n] && cinc == 0)
            cinc = 1;
        cnt = (32'(vc_count[n]) + cinc) & 32'hffff;
        if (cnt[15]) begin
            cnt = 0;
            lvl = lvl + linc;
            if (lvl < 0)
                lvl = 0;
            if (lvl > int'(mvae_pkg::LEVEL_MAX))
                lvl = int'(mvae_pkg::LEVEL_MAX);
            vc_level[n] = lvl[14:0];
        end
        vc_count[n] = cnt[15:0];

        // sustain holds until key off, stop or key on
        if (vc_phase[n] == mvae_pkg::PH_SUSTAIN)
            return;

        if ((!vc_dec[n] && lvl >= vc_target[n]) || (vc_dec[n] && lvl <= vc_target[n])) begin
            if (vc_phase[n] == mvae_pkg::PH_RELEASE)
                releases_done++;
            if (vc_phase[n] < mvae_pkg::PH_STOPPED)
                vc_phase[n] = vc_phase[n] + 3'd1;
            load_rates(n);
        end
        if (vc_phase[n] > mvae_pkg::PH_RELEASE)
            vc_on[n] = 1'b0;
    endfunction

    // Apply one accepted beat to the table and return the result it must give.
    function automatic mvae_pkg::t_result apply_voice_event(input mvae_pkg::t_item it);
        mvae_pkg::t_result r;
        int                n;
        beat_live = 1'b1;
        if (int'(it.voice) >= NUM_VOICES) begin
            // out of range voice: nothing touched, reported as a dead voice
            beat_live       = 1'b0;
            r.env_level_out = '0;
            r.phase_out     = mvae_pkg::PH_STOPPED;
            r.running_out   = 1'b0;
            return r;
        end
        n = int'(it.voice);
        case (it.kind)
            mvae_pkg::KIND_TICK: begin
                if (vc_on[n])
                    step_envelope(n);
                else
                    beat_live = 1'b0;
            end
            mvae_pkg::KIND_KEYON: begin
                vc_on[n]    = 1'b1;
                vc_level[n] = '0;
                vc_count[n] = '0;
                vc_phase[n] = mvae_pkg::PH_ATTACK;
                load_rates(n);
                keyons++;
            end
            mvae_pkg::KIND_KEYOFF: begin
                // also taken by an idle voice still sitting in attack/decay/sustain
                if (vc_phase[n] < mvae_pkg::PH_RELEASE) begin
                    vc_phase[n] = mvae_pkg::PH_RELEASE;
                    load_rates(n);
                end else begin
                    beat_live = 1'b0;
                end
            end
            mvae_pkg::KIND_STOP: begin
                vc_level[n] = '0;
                vc_phase[n] = mvae_pkg::PH_STOPPED;
                vc_on[n]    = 1'b0;
            end
            mvae_pkg::KIND_SET: begin
                // words land now, the rate cache picks them up at the next phase change
                vc_first[n]  = it.adsr_first_word;
                vc_second[n] = it.adsr_second_word;
            end
            default: begin
                beat_live = 1'b0;
            end
        endcase
        r.env_level_out = vc_level[n];
        r.phase_out     = vc_phase[n];
        r.running_out   = vc_on[n];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic mvae_pkg::t_item make_item(input logic [2:0] k, input logic [5:0] v,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b);
        mvae_pkg::t_item it;
        it.kind             = k;
        it.voice            = v;
        it.adsr_first_word  = a;
        it.adsr_second_word = b;
        return it;
    endfunction

    function automatic t_row drow(input logic [2:0] k, input logic [5:0] v,
                                  input logic [15:0] a, input logic [15:0] b,
                                  input logic typed, input logic [14:0] lvl,
                                  input logic [2:0] ph, input logic run);
        t_row rw;
        rw.beat                 = make_item(k, v, a, b);
        rw.typed                = typed;
        rw.want.env_level_out   = lvl;
        rw.want.phase_out       = ph;
        rw.want.running_out     = run;
        return rw;
    endfunction

    // attack/decay word, mostly with quick rates so notes get through their phases
    function automatic logic [15:0] pick_first();
        logic [15:0] a;
        a = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            a[14:10] = 5'($urandom_range(0, 2));
            a[7:4]   = 4'($urandom_range(0, 3));
        end
        return a;
    endfunction

    // sustain/release word, same idea
    function automatic logic [15:0] pick_second();
        logic [15:0] b;
        b = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            b[12:8] = 5'($urandom_range(0, 3));
            b[4:0]  = 5'($urandom_range(0, 2));
        end
        return b;
    endfunction

    // any kind, any voice code (48..63 included), any words
    function automatic mvae_pkg::t_item noise_item();
        return make_item(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                         16'($urandom), 16'($urandom));
    endfunction

    // Idle cycles before a beat: mostly none or short, now and then long, and
    // from time to time a calm run of back-to-back beats.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
            calm_left = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Present one beat and hold it until the block takes it. start/busy are
    // looked at on the falling edge so the decision never races the DUT flops.
    // start is left high on return; the next beat or a drain decides what follows.
    task automatic send_beat(input mvae_pkg::t_item it, input logic typed,
                             input mvae_pkg::t_result want);
        int                gap;
        mvae_pkg::t_result pred;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);           // beat taken at this edge
        pred = apply_voice_event(it);
        expected_env.push_back(typed ? want : pred);
        beats_sent++;
        if (beat_live)
            live_beats++;
    endtask

    // drop start and wait for every owed result; returns on a rising edge
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_env.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // a tick of the note's voice, with some unrelated traffic mixed in
    task automatic tick_with_noise(input logic [5:0] v);
        if ($urandom_range(0, 3) == 0)
            send_beat(noise_item(), 1'b0, '0);
        send_beat(make_item(mvae_pkg::KIND_TICK, v, 16'($urandom), 16'($urandom)),
                  1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed result
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_check
        mvae_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_env.size() == 0) begin
                errors++;
                $display("%0t: result with nothing owed: level %h phase %0d run %b",
                         $time, o_result.env_level_out, o_result.phase_out,
                         o_result.running_out);
            end else begin
                want = expected_env.pop_front();
                results_checked++;
                if (o_result.env_level_out !== want.env_level_out) begin
                    errors++;
                    $display("%0t: env_level_out expected %h actual %h",
                             $time, want.env_level_out, o_result.env_level_out);
                end
                if (o_result.phase_out !== want.phase_out) begin
                    errors++;
                    $display("%0t: phase_out expected %0d actual %0d",
                             $time, want.phase_out, o_result.phase_out);
                end
                if (o_result.running_out !== want.running_out) begin
                    errors++;
                    $display("%0t: running_out expected %b actual %b",
                             $time, want.running_out, o_result.running_out);
                end
            end
        end
    end

    // hard stop in case the handshake hangs
    initial begin
        #(TIME_LIMIT);
        $display("%0t: timeout, %0d results still owed", $time, expected_env.size());
        $display("multi_voice_adsr_envelope: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_row        dir_rows [$];
        logic [5:0]  v;
        int          hold;
        int          r;
        int          next_drain;

        for (int i = 0; i < NUM_VOICES; i++) begin
            vc_first[i]   = '0;
            vc_second[i]  = '0;
            vc_level[i]   = '0;
            vc_count[i]   = '0;
            vc_phase[i]   = mvae_pkg::PH_ATTACK;
            vc_on[i]      = 1'b0;
            vc_dec[i]     = 1'b0;
            vc_exp[i]     = 1'b0;
            vc_shift[i]   = 0;
            vc_step[i]    = 0;
            vc_target[i]  = 0;
            vc_endless[i] = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Typed rows are read straight off the spec; the rest
        // follow the predictor.
        // kind, voice, first, second / typed, level, phase, run
        // fresh table: idle tick, out of range voice, reserved kind
        dir_rows.push_back(drow(mvae_pkg::KIND_TICK, 6'd0, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_TICK, 6'd63, 16'hffff, 16'hffff,
                                1'b1, 15'd0, mvae_pkg::PH_STOPPED, 1'b0));
        dir_rows.push_back(drow(KIND_RSVD, 6'd2, 16'hffff, 16'hffff,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        // key off of an idle voice still in attack goes to release, stays idle
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYOFF, 6'd5, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_RELEASE, 1'b0));
        // second key off in release changes nothing
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYOFF, 6'd5, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_RELEASE, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYON, 6'd47, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b1));
        // full note on voice 0: fastest linear attack, decay straight through,
        // sustain rising toward the clamp, fast linear release down to stop
        dir_rows.push_back(drow(mvae_pkg::KIND_SET, 6'd0, 16'h000f, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYON, 6'd0, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b1));
        repeat (5)
            dir_rows.push_back(drow(mvae_pkg::KIND_TICK, 6'd0, 16'h0000, 16'h0000,
                                    1'b0, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYOFF, 6'd0, 16'h0000, 16'h0000,
                                1'b0, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        repeat (3)
            dir_rows.push_back(drow(mvae_pkg::KIND_TICK, 6'd0, 16'h0000, 16'h0000,
                                    1'b0, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_STOP, 6'd47, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_STOPPED, 1'b0));
        // all-ones words: endless attack, the level never moves
        dir_rows.push_back(drow(mvae_pkg::KIND_SET, 6'd3, 16'hffff, 16'hffff,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYON, 6'd3, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b1));
        dir_rows.push_back(drow(mvae_pkg::KIND_TICK, 6'd3, 16'h0000, 16'h0000,
                                1'b0, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        // exponential attack crossing the knee, exponential release set up
        dir_rows.push_back(drow(mvae_pkg::KIND_SET, 6'd4, 16'h8000, 16'h0020,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));
        dir_rows.push_back(drow(mvae_pkg::KIND_KEYON, 6'd4, 16'h0000, 16'h0000,
                                1'b1, 15'd0, mvae_pkg::PH_ATTACK, 1'b1));
        repeat (3)
            dir_rows.push_back(drow(mvae_pkg::KIND_TICK, 6'd4, 16'h0000, 16'h0000,
                                    1'b0, 15'd0, mvae_pkg::PH_ATTACK, 1'b0));

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        // Random notes: set words, key on, a run of ticks with unrelated beats
        // mixed in, then mostly a key off (sometimes a stop, sometimes nothing)
        // and more ticks so releases run out. Most notes land on a few voices
        // so the same entries get hit again and again.
        next_drain = DRAIN_EVERY;
        while (beats_sent < TARGET_BEATS) begin
            v = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                            : 6'($urandom_range(0, NUM_VOICES - 1));
            send_beat(make_item(mvae_pkg::KIND_SET, v, pick_first(), pick_second()),
                      1'b0, '0);
            send_beat(make_item(mvae_pkg::KIND_KEYON, v, 16'($urandom), 16'($urandom)),
                      1'b0, '0);
            hold = $urandom_range(4, 40);
            repeat (hold)
                tick_with_noise(v);
            r = $urandom_range(0, 9);
            if (r < 7)
                send_beat(make_item(mvae_pkg::KIND_KEYOFF, v, 16'($urandom),
                                    16'($urandom)), 1'b0, '0);
            else if (r == 7)
                send_beat(make_item(mvae_pkg::KIND_STOP, v, 16'($urandom),
                                    16'($urandom)), 1'b0, '0);
            hold = $urandom_range(2, 30);
            repeat (hold)
                tick_with_noise(v);
            if (beats_sent >= next_drain) begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_env.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_env.size());
        end

        $display("%0d beats sent (%0d changed state), %0d results checked",
                 beats_sent, live_beats, results_checked);
        $display("%0d key-ons, %0d notes released down to stop, %0d errors",
                 keyons, releases_done, errors);
        if (errors == 0)
            $display("multi_voice_adsr_envelope: match");
        else
            $display("multi_voice_adsr_envelope: mismatch");
        $finish;
    end

endmodule
